### sv/hsd_pkg.sv
// shared widths, status codes and the data-position table for the hamming decoder
package hsd_pkg;

	localparam int unsigned WordW = 31;
	localparam int unsigned LenW  = 5;
	localparam int unsigned SynW  = 5;
	localparam int unsigned DataW = 26;
	localparam int unsigned StatW = 2;

	typedef logic [WordW-1:0] word_t;
	typedef logic [LenW-1:0]  len_t;
	typedef logic [SynW-1:0]  syn_t;
	typedef logic [DataW-1:0] data_t;
	typedef logic [StatW-1:0] stat_t;

	localparam stat_t ST_NONE      = 2'd0;
	localparam stat_t ST_CORRECTED = 2'd1;
	localparam stat_t ST_BEYOND    = 2'd2;

	localparam len_t LEN_RESET = 5'd7;

	// word bit index of each message bit, skipping positions 1, 2, 4, 8 and 16
	localparam logic [4:0] DATA_IDX [DataW] = '{
		5'd2,  5'd4,  5'd5,  5'd6,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12,
		5'd13, 5'd14, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22,
		5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30
	};

endpackage

### sv/hamming_sec_decoder.sv
// single-error-correcting hamming decoder, one codeword per cycle while the result side keeps up
//
//  channel         | signals                                   | role
//  codeword        | codeword_valid, codeword_stall, codeword  | received word beats
//  result          | result_valid, result_stall, syndrome,     | decoded word beats
//                  | corrected_word, data_bits, error_status   |
//  cfg             | cfg_wr_en, cfg_wr_data                    | codeword length register
//
// two register stages: masked input word, then decoded result
// a beat is accepted every cycle while the result side keeps up
// an empty input stage still takes a beat while a stalled result waits in the output register
// reset clears both valid bits and sets the codeword length to seven
module hamming_sec_decoder
	import hsd_pkg::*;
#(
	parameter int unsigned MAX_LENGTH = 31
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_wr_en,
	input  len_t  cfg_wr_data,
	input  logic  codeword_valid,
	output logic  codeword_stall,
	input  word_t codeword,
	output logic  result_valid,
	input  logic  result_stall,
	output syn_t  syndrome,
	output word_t corrected_word,
	output data_t data_bits,
	output stat_t error_status
);

	len_t  len_q;
	len_t  eff_len;
	word_t len_mask;

	logic  valid_s1;
	word_t word_s1;
	len_t  len_s1;
	logic  adv_s1;
	logic  adv_s2;

	syn_t  syn_c;
	stat_t stat_c;
	word_t fixed_c;
	data_t data_c;

	logic  valid_s2;
	syn_t  syn_s2;
	word_t word_s2;
	data_t data_s2;
	stat_t stat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			len_q <= cfg_wr_data;
		end
	end

	// saturate at the build-time maximum
	always_comb begin
		eff_len = (int'(len_q) > int'(MAX_LENGTH)) ? LenW'(MAX_LENGTH) : len_q;
		for (int i = 0; i < WordW; i++) begin
			len_mask[i] = (LenW'(i) < eff_len);
		end
	end

	assign adv_s2         = !valid_s2 || !result_stall;
	assign adv_s1         = !valid_s1 || adv_s2;
	assign codeword_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= codeword_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && codeword_valid) begin
			word_s1 <= codeword & len_mask;
			len_s1  <= eff_len;
		end
	end

	// syndrome bit k is the parity of all positions with bit k set
	always_comb begin
		syn_c = '0;
		for (int k = 0; k < SynW; k++) begin
			for (int i = 0; i < WordW; i++) begin
				if (((i + 1) >> k) % 2 == 1) begin
					syn_c[k] = syn_c[k] ^ word_s1[i];
				end
			end
		end
	end

	always_comb begin
		priority if (syn_c == '0) begin
			stat_c = ST_NONE;
		end else if (syn_c <= len_s1) begin
			stat_c = ST_CORRECTED;
		end else begin
			stat_c = ST_BEYOND;
		end
		for (int i = 0; i < WordW; i++) begin
			fixed_c[i] = word_s1[i] ^ ((stat_c == ST_CORRECTED) && (syn_c == SynW'(i + 1)));
		end
		// bits above the length are already zero, so a fixed gather is enough
		for (int k = 0; k < DataW; k++) begin
			data_c[k] = fixed_c[DATA_IDX[k]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			syn_s2  <= syn_c;
			word_s2 <= fixed_c;
			data_s2 <= data_c;
			stat_s2 <= stat_c;
		end
	end

	assign result_valid   = valid_s2;
	assign syndrome       = syn_s2;
	assign corrected_word = word_s2;
	assign data_bits      = data_s2;
	assign error_status   = stat_s2;

endmodule

### sv/hsd_checker.sv
// port-level checks for the hamming decoder, bound to the top level
module hsd_checker
	import hsd_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  result_valid,
	input logic  result_stall,
	input syn_t  syndrome,
	input word_t corrected_word,
	input data_t data_bits,
	input stat_t error_status
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(syndrome)
			&& $stable(corrected_word) && $stable(data_bits) && $stable(error_status))
		else $error("stalled result beat changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> error_status == ST_NONE || error_status == ST_CORRECTED
			|| error_status == ST_BEYOND)
		else $error("unknown error status");

	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error_status == ST_NONE |-> syndrome == '0)
		else $error("no-error beat carries a syndrome");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error_status != ST_NONE |-> syndrome != '0)
		else $error("error beat with zero syndrome");

	// the flipped bit lies inside the word, so a corrected syndrome never names a position above 31
	a_flip: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error_status == ST_CORRECTED |-> syndrome <= SynW'(WordW))
		else $error("corrected position outside the word");

endmodule

bind hamming_sec_decoder hsd_checker u_hsd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.syndrome       (syndrome),
	.corrected_word (corrected_word),
	.data_bits      (data_bits),
	.error_status   (error_status)
);
